// ----- rtl/core/lpmr_pkg.sv -----
// Shared types, constants and control structs of the length-prefixed message ring.
package lpmr_pkg;

    localparam int BUF_BYTES = 4096;
    localparam int HDR_BYTES = 4;
    localparam int MAX_MSG   = 64;

    localparam int LEN_W  = 7;
    localparam int IDX_W  = LEN_W - 1;
    localparam int PTR_W  = $clog2(BUF_BYTES + 1);
    localparam int ADDR_W = $clog2(BUF_BYTES);

    localparam logic [2:0] REQ_WR_START = 3'd0;
    localparam logic [2:0] REQ_WR_BYTE  = 3'd1;
    localparam logic [2:0] REQ_READ     = 3'd2;
    localparam logic [2:0] REQ_PEEK     = 3'd3;
    localparam logic [2:0] REQ_DISCARD  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    typedef struct packed {
        logic [2:0]       req_type;
        logic [LEN_W-1:0] msg_length;
        logic [7:0]       data_byte;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic [LEN_W-1:0] head_length;
        logic             last;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_result;   // accepted request answered at once
        logic hdr_rd;      // read header byte at the read pointer
        logic len_latch;   // capture head length from the read data
        logic single_out;  // emit one result carrying only the head length
        logic byte_rd;     // read the next payload byte
        logic byte_out;    // emit the payload byte just read
        logic pop;         // drop the head record
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic empty;
        logic len_zero;
        logic byte_last;
    } stat_t;

endpackage

// ----- rtl/core/lpmr_ctrl.sv -----
// Request sequencer of the message ring: decides immediate answers and streams head records.
module lpmr_ctrl
    import lpmr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic [2:0] req_type,
    output logic       req_stall,
    input  stat_t      stat,
    output cmd_t       cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_HDR    = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_ISSUE  = 3'd3;
    localparam logic [2:0] S_LOAD   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [2:0] op_reg, op_next;
    logic       accept;
    logic       stream_req;

    assign req_stall  = !((state_reg == S_IDLE) && stat.out_free);
    assign accept     = req_valid && !req_stall;
    assign stream_req = (req_type == REQ_READ) || (req_type == REQ_PEEK) ||
                        (req_type == REQ_DISCARD);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (stream_req && !stat.empty)
                    begin
                        cmd.hdr_rd = 1'b1;
                        op_next    = req_type;
                        state_next = S_HDR;
                    end
                    else
                    begin
                        cmd.in_result = 1'b1;
                    end
                end
            end
            S_HDR:
            begin
                cmd.len_latch = 1'b1;
                state_next    = S_DECIDE;
            end
            S_DECIDE:
            begin
                if ((op_reg == REQ_DISCARD) || stat.len_zero)
                begin
                    if (stat.out_free)
                    begin
                        cmd.single_out = 1'b1;
                        cmd.pop        = (op_reg != REQ_PEEK);
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (stat.out_free)
                begin
                    cmd.byte_rd = 1'b1;
                    state_next  = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.byte_out = 1'b1;
                if (stat.byte_last)
                begin
                    cmd.pop    = (op_reg == REQ_READ);
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_ISSUE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= REQ_READ;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    // A payload byte is only emitted after its read was issued in the cycle before.
    a_load_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.byte_out |-> $past(cmd.byte_rd))
        else $error("byte emitted without a preceding read");

    // Streaming states never accept new requests.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> req_stall)
        else $error("request accepted while a record is streaming");

    // The pop of a peek never happens.
    a_peek_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop && (state_reg != S_IDLE)) |-> (op_reg != REQ_PEEK))
        else $error("peek removed the head record");

endmodule

// ----- rtl/core/lpmr_dp.sv -----
// Datapath of the message ring: byte store, pointers, occupancy and the result register.
module lpmr_dp
    import lpmr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  req_t  req,
    input  cmd_t  cmd,
    output stat_t stat,
    output logic  rsp_valid,
    input  logic  rsp_stall,
    output rsp_t  rsp
);

    localparam logic [PTR_W-1:0] BUF_C = PTR_W'(BUF_BYTES);
    localparam logic [PTR_W-1:0] HDR_C = PTR_W'(HDR_BYTES);
    localparam logic [LEN_W-1:0] MAX_C = LEN_W'(MAX_MSG);

    logic [7:0] mem [BUF_BYTES];
    logic [7:0] rdata_reg;

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W-1:0] wpt_reg, wpt_next;
    logic             wa_reg, wa_next;
    logic [PTR_W-1:0] used_reg, used_next;
    logic [LEN_W-1:0] left_reg, left_next;
    logic [LEN_W-1:0] open_len_reg, open_len_next;
    logic             wopen_reg, wopen_next;
    logic [LEN_W-1:0] hlen_reg, hlen_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             ovalid_reg, ovalid_next;
    rsp_t             out_reg, out_next;

    logic              used0;
    logic [PTR_W-1:0]  wp_e, rp_e, wpt_e;
    logic              wa_e;
    logic [PTR_W-1:0]  need, free_total, tail, base;
    logic              fit, do_wrap, start_ok;
    logic [PTR_W-1:0]  step, rp_adv;
    logic              hit;
    logic [LEN_W-1:0]  hdr_len;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata;

    assign used0      = (used_reg == '0);
    assign wp_e       = used0 ? '0 : wp_reg;
    assign rp_e       = used0 ? '0 : rp_reg;
    assign wpt_e      = used0 ? '0 : wpt_reg;
    assign wa_e       = used0 ? 1'b0 : wa_reg;
    assign need       = PTR_W'(req.msg_length) + HDR_C;
    assign free_total = BUF_C - used_reg;
    assign tail       = BUF_C - wp_e;
    assign fit        = (free_total >= need) && (tail >= need);
    assign do_wrap    = !fit && !wa_e && (tail < need) && (rp_e >= need);
    assign start_ok   = !wopen_reg && (req.msg_length <= MAX_C) && (fit || do_wrap);
    assign base       = do_wrap ? '0 : wp_e;

    assign step   = PTR_W'(hlen_reg) + HDR_C;
    assign rp_adv = rp_reg + step;
    assign hit    = wa_reg && (rp_adv == wpt_reg);

    assign hdr_len = (rdata_reg > 8'(MAX_C)) ? MAX_C : rdata_reg[LEN_W-1:0];

    assign stat.out_free  = !ovalid_reg || !rsp_stall;
    assign stat.empty     = used0;
    assign stat.len_zero  = (hlen_reg == '0);
    assign stat.byte_last = ({1'b0, idx_reg} + LEN_W'(1)) == hlen_reg;

    assign rsp_valid = ovalid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        wp_next       = wp_reg;
        rp_next       = rp_reg;
        wpt_next      = wpt_reg;
        wa_next       = wa_reg;
        used_next     = used_reg;
        left_next     = left_reg;
        open_len_next = open_len_reg;
        wopen_next    = wopen_reg;
        hlen_next     = hlen_reg;
        idx_next      = idx_reg;
        ovalid_next   = ovalid_reg && rsp_stall;
        out_next      = out_reg;
        mem_we        = 1'b0;
        mem_waddr     = wp_reg[ADDR_W-1:0];
        mem_wdata     = req.data_byte;
        mem_re        = 1'b0;
        mem_raddr     = rp_reg[ADDR_W-1:0];

        if (cmd.in_result)
        begin
            ovalid_next = 1'b1;
            out_next    = '0;
            out_next.last = 1'b1;
            case (req.req_type)
                REQ_WR_START:
                begin
                    if (wopen_reg || (req.msg_length > MAX_C))
                    begin
                        out_next.status = ST_BAD;
                    end
                    else if (!start_ok)
                    begin
                        out_next.status = ST_FULL;
                    end
                    else
                    begin
                        out_next.status = ST_OK;
                        mem_we        = 1'b1;
                        mem_waddr     = base[ADDR_W-1:0];
                        mem_wdata     = 8'(req.msg_length);
                        wp_next       = base + HDR_C;
                        rp_next       = rp_e;
                        wpt_next      = do_wrap ? wp_e : wpt_e;
                        wa_next       = do_wrap || wa_e;
                        used_next     = used_reg + (do_wrap ? tail : '0) +
                                        ((req.msg_length == '0) ? HDR_C : '0);
                        wopen_next    = (req.msg_length != '0);
                        left_next     = req.msg_length;
                        open_len_next = req.msg_length;
                    end
                end
                REQ_WR_BYTE:
                begin
                    if (!wopen_reg)
                    begin
                        out_next.status = ST_BAD;
                    end
                    else
                    begin
                        out_next.status = ST_OK;
                        mem_we  = 1'b1;
                        wp_next = wp_reg + PTR_W'(1);
                        if (left_reg == LEN_W'(1))
                        begin
                            used_next     = used_reg + PTR_W'(open_len_reg) + HDR_C;
                            wopen_next    = 1'b0;
                            left_next     = '0;
                            open_len_next = '0;
                        end
                        else
                        begin
                            left_next = left_reg - LEN_W'(1);
                        end
                    end
                end
                REQ_READ, REQ_PEEK, REQ_DISCARD:
                begin
                    out_next.status = ST_EMPTY;
                end
                default:
                begin
                    out_next.status = ST_BAD;
                end
            endcase
        end

        if (cmd.hdr_rd)
        begin
            mem_re    = 1'b1;
            mem_raddr = rp_reg[ADDR_W-1:0];
        end

        if (cmd.len_latch)
        begin
            hlen_next = hdr_len;
            idx_next  = '0;
        end

        if (cmd.single_out)
        begin
            ovalid_next = 1'b1;
            out_next    = '0;
            out_next.status      = ST_OK;
            out_next.head_length = hlen_reg;
            out_next.last        = 1'b1;
        end

        if (cmd.byte_rd)
        begin
            mem_re    = 1'b1;
            mem_raddr = ADDR_W'(rp_reg + HDR_C + PTR_W'(idx_reg));
        end

        if (cmd.byte_out)
        begin
            ovalid_next = 1'b1;
            out_next.status      = ST_OK;
            out_next.out_byte    = rdata_reg;
            out_next.byte_valid  = 1'b1;
            out_next.head_length = hlen_reg;
            out_next.last        = stat.byte_last;
            idx_next             = idx_reg + IDX_W'(1);
        end

        // Dropping the head releases the skipped tail once the wrap mark is reached.
        if (cmd.pop)
        begin
            used_next = used_reg - step - (hit ? (BUF_C - wpt_reg) : '0);
            rp_next   = hit ? '0 : rp_adv;
            if (hit)
            begin
                wpt_next = '0;
                wa_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            rp_reg       <= '0;
            wpt_reg      <= '0;
            wa_reg       <= 1'b0;
            used_reg     <= '0;
            left_reg     <= '0;
            open_len_reg <= '0;
            wopen_reg    <= 1'b0;
            hlen_reg     <= '0;
            idx_reg      <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            wpt_reg      <= wpt_next;
            wa_reg       <= wa_next;
            used_reg     <= used_next;
            left_reg     <= left_next;
            open_len_reg <= open_len_next;
            wopen_reg    <= wopen_next;
            hlen_reg     <= hlen_next;
            idx_reg      <= idx_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= BUF_C)
        else $error("occupancy exceeds the store size");

    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= BUF_C)
        else $error("write pointer beyond the store");

    a_wrap_mark: assert property (@(posedge clk) disable iff (!rst_n)
        !wa_reg |-> (wpt_reg == '0))
        else $error("wrap mark left set after release");

    a_out_empty_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.byte_out |-> !ovalid_reg)
        else $error("payload byte would overwrite a pending result");

endmodule

// ----- rtl/core/length_prefixed_message_ring.sv -----
// Top level of the length-prefixed message ring: sequencer plus datapath.
//
//  channel | direction | payload | handshake
//  req     | in        | req_t   | req_valid / req_stall
//  rsp     | out       | rsp_t   | rsp_valid / rsp_stall
//
// Write start, write byte, rejected and empty requests are answered at once from the idle state.
// Read, peek and discard fetch the header byte through the store's registered read port,
// latch the length and decide, then read and load each payload byte in turn.
// Reset clears pointers, occupancy and control; the byte store needs no clearing.
// A stalled result holds the sequencer; new requests wait until a record is fully out.
module length_prefixed_message_ring
    import lpmr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    cmd_t  cmd;
    stat_t stat;

    lpmr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req_data.req_type),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    lpmr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp_data)
    );

endmodule

// ----- tb/tb_length_prefixed_message_ring.sv -----
// Self-checking testbench of the length-prefixed message ring with a shadow ring model.
`timescale 1ns / 100ps

module tb_length_prefixed_message_ring;
    import lpmr_pkg::*;

    localparam int IDLE_PCT   = 27;
    localparam int STUCK_MAX  = 2000;
    localparam int TAIL_WAIT  = 20;
    localparam int RAND_ITEMS = 240;
    localparam int REQ_CODES  = 8;
    localparam int CALM_FROM  = 150;
    localparam int CALM_TO    = 260;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data  = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_data;

    req_t pending_req [$];
    rsp_t expected_rsp [$];
    rsp_t want_rsp;
    logic calm;
    int   err_count    = 0;
    int   req_count    = 0;
    int   rsp_count    = 0;
    int   queued_count = 0;
    int   stuck_cycles = 0;

    // Shadow copy of the ring state.
    logic [7:0]       ring_mem [BUF_BYTES];
    logic [PTR_W-1:0] wr_ptr     = '0;
    logic [PTR_W-1:0] rd_ptr     = '0;
    logic [PTR_W-1:0] wrap_at    = '0;
    logic [PTR_W-1:0] used_bytes = '0;
    logic [LEN_W-1:0] open_len      = '0;
    logic [LEN_W-1:0] left_to_write = '0;
    logic             writing      = 1'b0;
    logic             wrapped      = 1'b0;
    int               record_count = 0;

    length_prefixed_message_ring u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Both sides run without gaps for a stretch of the random traffic.
    assign calm = (req_count >= CALM_FROM) && (req_count < CALM_TO);

    function automatic void push_rsp(logic [1:0] st, logic [7:0] b, logic v,
                                     logic [LEN_W-1:0] hl, logic lst);
        rsp_t r;
        r.status      = st;
        r.out_byte    = b;
        r.byte_valid  = v;
        r.head_length = hl;
        r.last        = lst;
        expected_rsp.push_back(r);
    endfunction

    function automatic void commit_record();
        used_bytes    = used_bytes + PTR_W'(int'(open_len) + HDR_BYTES);
        writing       = 1'b0;
        left_to_write = '0;
        open_len      = '0;
        record_count++;
    endfunction

    function automatic void pop_record(int len);
        used_bytes = used_bytes - PTR_W'(len + HDR_BYTES);
        rd_ptr     = rd_ptr + PTR_W'(len + HDR_BYTES);
        // Reaching the wrap mark gives back the skipped tail.
        if (wrapped && rd_ptr == wrap_at)
        begin
            used_bytes = used_bytes - PTR_W'(BUF_BYTES - int'(wrap_at));
            rd_ptr     = '0;
            wrap_at    = '0;
            wrapped    = 1'b0;
        end
        record_count--;
    endfunction

    function automatic void predict_request(req_t r);
        int          need;
        int          len;
        int          i;
        logic [31:0] hdr;
        bit          fits;
        need = int'(r.msg_length) + HDR_BYTES;
        hdr  = '0;
        fits = 1'b0;
        case (r.req_type)
            REQ_WR_START:
            begin
                if (writing || r.msg_length > MAX_MSG)
                begin
                    push_rsp(ST_BAD, 8'd0, 1'b0, '0, 1'b1);
                end
                else
                begin
                    if (used_bytes == 0)
                    begin
                        wr_ptr  = '0;
                        rd_ptr  = '0;
                        wrap_at = '0;
                        wrapped = 1'b0;
                    end
                    if (BUF_BYTES - int'(used_bytes) >= need && BUF_BYTES - int'(wr_ptr) >= need)
                    begin
                        fits = 1'b1;
                    end
                    else if (!wrapped && BUF_BYTES - int'(wr_ptr) < need && int'(rd_ptr) >= need)
                    begin
                        wrap_at    = wr_ptr;
                        wrapped    = 1'b1;
                        used_bytes = used_bytes + PTR_W'(BUF_BYTES - int'(wr_ptr));
                        wr_ptr     = '0;
                        fits       = 1'b1;
                    end
                    if (!fits)
                    begin
                        push_rsp(ST_FULL, 8'd0, 1'b0, '0, 1'b1);
                    end
                    else
                    begin
                        hdr = 32'(r.msg_length);
                        for (i = 0; i < HDR_BYTES; i++)
                            ring_mem[(int'(wr_ptr) + i) % BUF_BYTES] = hdr[8*i +: 8];
                        wr_ptr        = wr_ptr + PTR_W'(HDR_BYTES);
                        open_len      = r.msg_length;
                        left_to_write = r.msg_length;
                        writing       = 1'b1;
                        if (r.msg_length == 0)
                            commit_record();
                        push_rsp(ST_OK, 8'd0, 1'b0, '0, 1'b1);
                    end
                end
            end
            REQ_WR_BYTE:
            begin
                if (!writing)
                begin
                    push_rsp(ST_BAD, 8'd0, 1'b0, '0, 1'b1);
                end
                else
                begin
                    ring_mem[int'(wr_ptr) % BUF_BYTES] = r.data_byte;
                    wr_ptr        = wr_ptr + PTR_W'(1);
                    left_to_write = left_to_write - LEN_W'(1);
                    if (left_to_write == 0)
                        commit_record();
                    push_rsp(ST_OK, 8'd0, 1'b0, '0, 1'b1);
                end
            end
            REQ_READ, REQ_PEEK, REQ_DISCARD:
            begin
                if (used_bytes == 0)
                begin
                    push_rsp(ST_EMPTY, 8'd0, 1'b0, '0, 1'b1);
                end
                else
                begin
                    for (i = 0; i < HDR_BYTES; i++)
                        hdr[8*i +: 8] = ring_mem[(int'(rd_ptr) + i) % BUF_BYTES];
                    len = (hdr > MAX_MSG) ? MAX_MSG : int'(hdr);
                    if (r.req_type == REQ_DISCARD || len == 0)
                    begin
                        push_rsp(ST_OK, 8'd0, 1'b0, LEN_W'(len), 1'b1);
                        if (r.req_type != REQ_PEEK)
                            pop_record(len);
                    end
                    else
                    begin
                        for (i = 0; i < len; i++)
                            push_rsp(ST_OK,
                                     ring_mem[(int'(rd_ptr) + HDR_BYTES + i) % BUF_BYTES],
                                     1'b1, LEN_W'(len), i + 1 == len);
                        if (r.req_type == REQ_READ)
                            pop_record(len);
                    end
                end
            end
            default:
            begin
                push_rsp(ST_BAD, 8'd0, 1'b0, '0, 1'b1);
            end
        endcase
    endfunction

    task automatic report_mismatch(string what);
        $display("ERROR at %0t, result %0d: %s", $time, rsp_count, what);
        err_count++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task automatic queue_req(logic [2:0] kind, logic [LEN_W-1:0] len, logic [7:0] data);
        req_t r;
        r.req_type   = kind;
        r.msg_length = len;
        r.data_byte  = data;
        pending_req.push_back(r);
        queued_count++;
    endtask

    // Request whose length and data fields are not used by the block.
    task automatic queue_ctl(logic [2:0] kind);
        queue_req(kind, LEN_W'($urandom), 8'($urandom));
    endtask

    task automatic queue_record(int len);
        int k;
        queue_req(REQ_WR_START, LEN_W'(len), 8'($urandom));
        for (k = 0; k < len; k++)
            queue_req(REQ_WR_BYTE, LEN_W'($urandom), 8'($urandom));
    endtask

    // The sender holds off until every expected result has come back.
    task automatic wait_idle();
        while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0)
            @(negedge clk);
    endtask

    task automatic drain_records();
        int k;
        int n;
        wait_idle();
        n = record_count;
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < 5)
                queue_ctl(REQ_PEEK);
            queue_ctl($urandom_range(1) ? REQ_READ : REQ_DISCARD);
        end
        wait_idle();
    endtask

    // Request driver: presents queued requests and updates the shadow model on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data  <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                predict_request(req_data);
                req_count <= req_count + 1;
            end
            if (!req_valid || !req_stall)
            begin
                if (pending_req.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    req_valid <= 1'b1;
                    req_data  <= pending_req.pop_front();
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random stalls and in-order comparison.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                rsp_count <= rsp_count + 1;
                if (expected_rsp.size() == 0)
                begin
                    report_mismatch("result arrived with nothing expected");
                end
                else
                begin
                    want_rsp = expected_rsp.pop_front();
                    check_field("status", rsp_data.status, want_rsp.status);
                    check_field("out_byte", rsp_data.out_byte, want_rsp.out_byte);
                    check_field("byte_valid", rsp_data.byte_valid, want_rsp.byte_valid);
                    check_field("head_length", rsp_data.head_length, want_rsp.head_length);
                    check_field("last", rsp_data.last, want_rsp.last);
                end
            end
            rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        wait (stuck_cycles >= STUCK_MAX);
        $display("ERROR: no handshake for %0d cycles", STUCK_MAX);
        $display("tb_length_prefixed_message_ring NOT OK");
        $finish;
    end

    initial
    begin
        int sel;
        int len;
        int nbytes;
        int k;
        int start_n;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed requests: empty store, bad codes and lengths, zero-length records.
        queue_ctl(REQ_READ);
        queue_ctl(REQ_PEEK);
        queue_ctl(REQ_DISCARD);
        queue_req(REQ_WR_BYTE, '1, 8'hFF);
        for (k = int'(REQ_DISCARD) + 1; k < REQ_CODES; k++)
            queue_req(3'(k), '1, 8'hFF);
        queue_req(REQ_WR_START, LEN_W'(MAX_MSG + 1), 8'h00);
        queue_req(REQ_WR_START, '1, 8'hFF);
        queue_req(REQ_WR_START, '0, 8'h00);
        queue_ctl(REQ_PEEK);
        queue_ctl(REQ_READ);
        queue_req(REQ_WR_START, LEN_W'(3), 8'h00);
        queue_req(REQ_WR_BYTE, '0, 8'h00);
        queue_req(REQ_WR_BYTE, '1, 8'hFF);
        queue_req(REQ_WR_BYTE, '0, 8'h5A);
        queue_req(REQ_WR_START, LEN_W'(2), 8'h00);
        // A second write start while one is open is refused.
        queue_req(REQ_WR_START, LEN_W'(1), 8'h00);
        queue_req(REQ_WR_BYTE, '0, 8'h81);
        queue_req(REQ_WR_BYTE, '0, 8'h7E);
        queue_ctl(REQ_PEEK);
        queue_ctl(REQ_DISCARD);
        queue_ctl(REQ_READ);
        queue_ctl(REQ_READ);
        wait_idle();

        // Random traffic, mostly well-formed records mixed with reads and noise.
        start_n = queued_count;
        while (queued_count - start_n < RAND_ITEMS)
        begin
            sel = $urandom_range(99);
            if (sel < 50)
            begin
                sel = $urandom_range(99);
                if (sel < 6)
                    len = $urandom_range(127, MAX_MSG + 1);
                else if (sel < 12)
                    len = MAX_MSG;
                else if (sel < 30)
                    len = $urandom_range(MAX_MSG - 1, 13);
                else
                    len = $urandom_range(12, 0);
                queue_req(REQ_WR_START, LEN_W'(len), 8'($urandom));
                nbytes = (len > MAX_MSG) ? 0 : len;
                // A few records are cut short; the open record then takes later write bytes.
                if (nbytes != 0 && $urandom_range(99) < 8)
                    nbytes = $urandom_range(nbytes - 1, 0);
                for (k = 0; k < nbytes; k++)
                begin
                    if ($urandom_range(99) < 8)
                        queue_ctl(3'($urandom_range(REQ_DISCARD, REQ_READ)));
                    queue_req(REQ_WR_BYTE, LEN_W'($urandom), 8'($urandom));
                end
            end
            else if (sel < 75)
                queue_ctl(REQ_READ);
            else if (sel < 83)
                queue_ctl(REQ_PEEK);
            else if (sel < 91)
                queue_ctl(REQ_DISCARD);
            else
                queue_req(3'($urandom), LEN_W'($urandom), 8'($urandom));
            if ($urandom_range(99) < 4)
                wait_idle();
        end

        // Close any open record, then empty the store.
        wait_idle();
        for (k = 0; k < int'(left_to_write); k++)
            queue_req(REQ_WR_BYTE, LEN_W'($urandom), 8'($urandom));
        drain_records();

        // An empty store answers empty, then takes a fresh record from address zero.
        queue_ctl(REQ_READ);
        queue_record(5);
        queue_ctl(REQ_READ);

        wait_idle();
        repeat (TAIL_WAIT) @(posedge clk);
        if (expected_rsp.size() != 0)
            report_mismatch($sformatf("%0d expected results never came", expected_rsp.size()));

        $display("Ran %0d requests with %0d results: empty, refused and unknown requests,",
                 req_count, rsp_count);
        $display("zero-length and maximum records, short writes, peeks, discards and drains.");
        if (err_count == 0)
            $display("tb_length_prefixed_message_ring OK");
        else
            $display("tb_length_prefixed_message_ring NOT OK");
        $finish;
    end

endmodule
